[rtl/dpsp_pkg.sv]
// ----------------------------------------------------------------------------
// dpsp_pkg
// Types, constants and pattern tables shared by the drum pattern player.
// ----------------------------------------------------------------------------
package dpsp_pkg;

  // sample store geometry
  localparam int MAX_SAMPLES = 4096;
  localparam int SAMP_AW     = $clog2(MAX_SAMPLES);
  localparam int STORE_AW    = SAMP_AW + 2;
  localparam int LEN_W       = 13;
  localparam int STEP_W      = 4;
  localparam int POS_W       = 4;

  // pattern limits (index of last entry)
  localparam logic [POS_W-1:0] ROCK_LAST  = 4'd2;
  localparam logic [POS_W-1:0] POP_LAST   = 4'd2;
  localparam logic [POS_W-1:0] SAMBA_LAST = 4'd9;

  // step reset values
  localparam logic [STEP_W-1:0] CLAP_STEP_RST    = 4'd1;
  localparam logic [STEP_W-1:0] BASS_STEP_RST    = 4'd3;
  localparam logic [STEP_W-1:0] MARACAS_STEP_RST = 4'd2;
  localparam logic [STEP_W-1:0] BONGO_STEP_RST   = 4'd4;

  // queue depths
  localparam int FQ_DEPTH = 2;
  localparam int FQ_AW    = $clog2(FQ_DEPTH);
  localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);
  localparam int RQ_DEPTH = 4;
  localparam int RQ_AW    = $clog2(RQ_DEPTH);
  localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

  // input mode codes
  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_RHYTHM = 2'd1;
  localparam logic [1:0] MODE_PAUSE  = 2'd2;
  localparam logic [1:0] MODE_LOAD   = 2'd3;

  // rhythm codes
  localparam logic [1:0] RHY_ROCK    = 2'd0;
  localparam logic [1:0] RHY_POP     = 2'd1;
  localparam logic [1:0] RHY_SAMBA   = 2'd2;
  localparam logic [1:0] RHY_RESTART = 2'd3;

  // instrument codes
  localparam logic [1:0] INS_CLAP    = 2'd0;
  localparam logic [1:0] INS_BASS    = 2'd1;
  localparam logic [1:0] INS_MARACAS = 2'd2;
  localparam logic [1:0] INS_BONGO   = 2'd3;

  // register indexes
  localparam logic [2:0] REG_CLAP_LEN    = 3'd0;
  localparam logic [2:0] REG_BASS_LEN    = 3'd1;
  localparam logic [2:0] REG_MARACAS_LEN = 3'd2;
  localparam logic [2:0] REG_BONGO_LEN   = 3'd3;
  localparam logic [2:0] REG_CLAP_STEP   = 3'd4;
  localparam logic [2:0] REG_BASS_STEP   = 3'd5;
  localparam logic [2:0] REG_MARACAS_STEP = 3'd6;
  localparam logic [2:0] REG_BONGO_STEP  = 3'd7;

  // pattern tables, one entry per pattern position, entry 15 on the left
  localparam logic [15:0][1:0] PAT_ROCK = {
    INS_BASS, INS_CLAP, INS_BASS, INS_BASS, INS_CLAP, INS_BASS, INS_BASS, INS_CLAP,
    INS_BASS, INS_BASS, INS_CLAP, INS_BASS, INS_BASS, INS_CLAP, INS_BASS, INS_BASS};
  localparam logic [15:0][1:0] PAT_POP = {
    INS_CLAP, INS_BASS, INS_CLAP, INS_CLAP, INS_BASS, INS_CLAP, INS_CLAP, INS_BASS,
    INS_CLAP, INS_CLAP, INS_BASS, INS_CLAP, INS_CLAP, INS_BASS, INS_CLAP, INS_CLAP};
  localparam logic [15:0][1:0] PAT_SAMBA = {
    INS_MARACAS, INS_MARACAS, INS_MARACAS, INS_MARACAS, INS_MARACAS, INS_MARACAS,
    INS_BONGO, INS_BONGO, INS_BONGO,
    INS_MARACAS, INS_MARACAS, INS_MARACAS, INS_MARACAS, INS_MARACAS, INS_MARACAS,
    INS_MARACAS};

  typedef struct packed {
    logic [1:0]          mode;
    logic [1:0]          rhythm_choice;
    logic [STORE_AW-1:0] load_address;
    logic [7:0]          load_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       pwm_value;
    logic             pwm_valid;
    logic [1:0]       current_instrument;
    logic [POS_W-1:0] pattern_position;
    logic             paused_flag;
  } out_item_t;

  // classified request between front and back
  typedef struct packed {
    logic                is_tick;
    logic                is_rhythm;
    logic                is_pause;
    logic                is_load;
    logic                restart;
    logic [1:0]          choice;
    logic [STORE_AW-1:0] addr;
    logic [7:0]          data;
  } fe_req_t;

  typedef struct packed {
    logic [3:0][LEN_W-1:0]  len;
    logic [3:0][STEP_W-1:0] step;
  } cfg_t;

  // handshake status from the result queue to the back end
  typedef struct packed {
    logic [RQ_CW-1:0] count;
  } rq_stat_t;

  function automatic logic [1:0] pattern_entry(input logic [1:0] sel,
                                               input logic [POS_W-1:0] pos);
    logic [1:0] ins;
    unique case (sel)
      RHY_ROCK: ins = PAT_ROCK[pos];
      RHY_POP:  ins = PAT_POP[pos];
      default:  ins = PAT_SAMBA[pos];
    endcase
    return ins;
  endfunction

  function automatic logic [POS_W-1:0] pattern_limit(input logic [1:0] sel);
    logic [POS_W-1:0] lim;
    unique case (sel)
      RHY_ROCK: lim = ROCK_LAST;
      RHY_POP:  lim = POP_LAST;
      default:  lim = SAMBA_LAST;
    endcase
    return lim;
  endfunction

endpackage

[rtl/dpsp_front.sv]
// ----------------------------------------------------------------------------
// dpsp_front
// Input queue: accepts requests, decodes the mode and holds them for the back.
// ----------------------------------------------------------------------------
module dpsp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  dpsp_pkg::in_item_t in_item,
  output logic               fe_valid,
  input  logic               fe_take,
  output dpsp_pkg::fe_req_t  fe_req
);
  import dpsp_pkg::*;

  fe_req_t          q_r [FQ_DEPTH];
  logic [FQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FQ_CW-1:0] count_r;
  fe_req_t          cls;
  logic             do_push, do_pop;

  // classify the incoming request
  always_comb begin
    cls           = '0;
    cls.is_tick   = (in_item.mode == MODE_TICK);
    cls.is_rhythm = (in_item.mode == MODE_RHYTHM);
    cls.is_pause  = (in_item.mode == MODE_PAUSE);
    cls.is_load   = (in_item.mode == MODE_LOAD);
    cls.restart   = (in_item.rhythm_choice == RHY_RESTART);
    cls.choice    = in_item.rhythm_choice;
    cls.addr      = in_item.load_address;
    cls.data      = in_item.load_data;
  end

  assign full     = (count_r == FQ_CW'(FQ_DEPTH));
  assign fe_valid = (count_r != '0);
  assign fe_req   = q_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = fe_take && fe_valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

endmodule

[rtl/dpsp_back.sv]
// ----------------------------------------------------------------------------
// dpsp_back
// Playback engine: sequencer state, sample store and result assembly.
// ----------------------------------------------------------------------------
module dpsp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  dpsp_pkg::cfg_t      cfg,
  input  logic                fe_valid,
  output logic                fe_take,
  input  dpsp_pkg::fe_req_t   fe_req,
  input  dpsp_pkg::rq_stat_t  rq_stat,
  output logic                res_valid,
  output dpsp_pkg::out_item_t res_item
);
  import dpsp_pkg::*;

  // sequencer state
  logic             active_r, active_nxt;
  logic [1:0]       sel_r, sel_nxt;
  logic [POS_W-1:0] ppos_r, ppos_nxt;
  logic [1:0]       ins_r, ins_nxt;
  logic [LEN_W-1:0] spos_r, spos_nxt;
  logic             paused_r, paused_nxt;

  // stage after execute
  logic             s1_v_r;
  out_item_t        s1_r, s1_nxt;

  // sample store
  logic [7:0]          mem [4*MAX_SAMPLES];
  logic [7:0]          rd_data_r;
  logic                rd_en, wr_en;
  logic [STORE_AW-1:0] rd_addr;

  logic [LEN_W-1:0]  len_raw, len_c;
  logic [STEP_W:0]   adv;
  logic [RQ_CW-1:0]  used;
  logic [1:0]        new_sel;

  // room check: results in flight plus queued must fit the result queue
  assign used    = rq_stat.count + RQ_CW'(s1_v_r);
  assign fe_take = fe_valid && (used < RQ_CW'(RQ_DEPTH));

  assign len_raw = cfg.len[ins_r];
  assign len_c   = (len_raw > LEN_W'(MAX_SAMPLES)) ? LEN_W'(MAX_SAMPLES) : len_raw;
  assign adv     = (sel_r == RHY_POP) ? {cfg.step[ins_r], 1'b0} : {1'b0, cfg.step[ins_r]};
  assign rd_addr = {ins_r, spos_r[SAMP_AW-1:0]};
  assign new_sel = fe_req.restart ? sel_r : fe_req.choice;

  // execute one request
  always_comb begin
    active_nxt = active_r;
    sel_nxt    = sel_r;
    ppos_nxt   = ppos_r;
    ins_nxt    = ins_r;
    spos_nxt   = spos_r;
    paused_nxt = paused_r;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    s1_nxt     = '0;
    priority if (fe_req.is_tick) begin
      if (active_r) begin
        if (spos_r >= len_c) begin
          // end of sample: move to the next pattern entry
          ins_nxt  = pattern_entry(sel_r, ppos_r);
          ppos_nxt = (ppos_r >= pattern_limit(sel_r)) ? '0 : ppos_r + 1'b1;
          spos_nxt = '0;
        end else if (!paused_r) begin
          rd_en            = 1'b1;
          s1_nxt.pwm_valid = 1'b1;
          spos_nxt         = spos_r + LEN_W'(adv);
        end
      end
    end else if (fe_req.is_rhythm) begin
      if (!fe_req.restart || active_r) begin
        sel_nxt    = new_sel;
        active_nxt = 1'b1;
        ins_nxt    = pattern_entry(new_sel, '0);
        ppos_nxt   = (pattern_limit(new_sel) == '0) ? '0 : POS_W'(1);
        spos_nxt   = '0;
      end
    end else if (fe_req.is_pause) begin
      paused_nxt = !paused_r;
    end else begin
      wr_en = 1'b1;
    end
    s1_nxt.current_instrument = ins_nxt;
    s1_nxt.pattern_position   = ppos_nxt;
    s1_nxt.paused_flag        = paused_nxt;
  end

  // sample store port, read data registered
  always_ff @(posedge clk) begin
    if (fe_take && wr_en) begin
      mem[fe_req.addr] <= fe_req.data;
    end
    if (fe_take && rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // state and stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      sel_r    <= RHY_ROCK;
      ppos_r   <= '0;
      ins_r    <= INS_CLAP;
      spos_r   <= '0;
      paused_r <= 1'b0;
      s1_v_r   <= 1'b0;
    end else begin
      s1_v_r <= fe_take;
      if (fe_take) begin
        active_r <= active_nxt;
        sel_r    <= sel_nxt;
        ppos_r   <= ppos_nxt;
        ins_r    <= ins_nxt;
        spos_r   <= spos_nxt;
        paused_r <= paused_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fe_take) begin
      s1_r <= s1_nxt;
    end
  end

  // merge the store byte into the result
  always_comb begin
    res_item           = s1_r;
    res_item.pwm_value = s1_r.pwm_valid ? rd_data_r : 8'd0;
  end
  assign res_valid = s1_v_r;

endmodule

[rtl/dpsp_rq.sv]
// ----------------------------------------------------------------------------
// dpsp_rq
// Result queue: holds finished results until the receiver pops them.
// ----------------------------------------------------------------------------
module dpsp_rq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_valid,
  input  dpsp_pkg::out_item_t res_item,
  output dpsp_pkg::rq_stat_t  rq_stat,
  output logic                empty,
  input  logic                pop,
  output dpsp_pkg::out_item_t out_item
);
  import dpsp_pkg::*;

  out_item_t        q_r [RQ_DEPTH];
  logic [RQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [RQ_CW-1:0] count_r;
  logic             do_pop;

  assign empty         = (count_r == '0);
  assign out_item      = q_r[rd_ptr_r];
  assign do_pop        = pop && !empty;
  assign rq_stat.count = count_r;

  // storage; the back end only sends when there is room
  always_ff @(posedge clk) begin
    if (res_valid) begin
      q_r[wr_ptr_r] <= res_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (res_valid) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)    rd_ptr_r <= rd_ptr_r + 1'b1;
      if (res_valid && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !res_valid) count_r <= count_r - 1'b1;
    end
  end

endmodule

[rtl/drum_pattern_sample_player.sv]
// ----------------------------------------------------------------------------
// drum_pattern_sample_player
// Drum machine sequencer: plays stored instrument waveforms in fixed patterns.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue (push/full, in_item): one request per accepted item: sample
//   tick, rhythm select, pause toggle or a sample store byte load.
//   Result queue (empty/pop, out_item): exactly one result per request, in
//   order; the oldest waiting result sits on out_item while empty is low.
//   Register port (APB): four waveform lengths and four step sizes at byte
//   addresses 4*i; write only while no request is outstanding.
//   Throughput is one request per cycle while the result queue has room: the
//   sequencer state update and the single-port sample store access both happen
//   in the cycle a request is taken. From accept to a visible result a request
//   passes the input queue, the registered read stage and the result queue.
//   Reset clears the sequencer (no rhythm, playing), lengths to zero and steps
//   to their defaults; the sample store is not cleared and must be loaded.
//   When the receiver stalls, results collect in a four-entry queue, the
//   engine stops once it is full and the two-entry input queue then raises
//   full.
// ----------------------------------------------------------------------------
module drum_pattern_sample_player (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  dpsp_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output dpsp_pkg::out_item_t out_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import dpsp_pkg::*;

  cfg_t      cfg_r;
  logic      fe_valid, fe_take;
  fe_req_t   fe_req;
  rq_stat_t  rq_stat;
  logic      res_valid;
  out_item_t res_item;
  logic [2:0] reg_idx;
  logic       wr_req;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_req  = psel && penable && pwrite;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.len  <= '0;
      cfg_r.step <= {BONGO_STEP_RST, MARACAS_STEP_RST, BASS_STEP_RST, CLAP_STEP_RST};
    end else if (wr_req) begin
      if (!reg_idx[2]) cfg_r.len[reg_idx[1:0]]  <= pwdata[LEN_W-1:0];
      else             cfg_r.step[reg_idx[1:0]] <= pwdata[STEP_W-1:0];
    end
  end

  // register readback
  always_comb begin
    if (!reg_idx[2]) prdata = 32'(cfg_r.len[reg_idx[1:0]]);
    else             prdata = 32'(cfg_r.step[reg_idx[1:0]]);
  end

  dpsp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .fe_valid (fe_valid),
    .fe_take  (fe_take),
    .fe_req   (fe_req)
  );

  dpsp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .fe_valid  (fe_valid),
    .fe_take   (fe_take),
    .fe_req    (fe_req),
    .rq_stat   (rq_stat),
    .res_valid (res_valid),
    .res_item  (res_item)
  );

  dpsp_rq u_rq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_item  (res_item),
    .rq_stat   (rq_stat),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item)
  );

endmodule
